/* rtl/core/dvwa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvwa_pkg
// Shared types and constants of the decompressor vm word alu: request and
// response payloads, operation and status codes, controller interface structs.
// ----------------------------------------------------------------------------
package dvwa_pkg;

    // byte memory size, a power of two so that address wrap is a mask
    localparam int MEM_BYTES  = 65536;
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int WORD_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int DIV_STEPS  = WORD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // operation codes, codes above OP_READ behave like a read
    typedef enum logic [3:0] {
        OP_AND    = 4'd0,
        OP_OR     = 4'd1,
        OP_NOT    = 4'd2,
        OP_LSHIFT = 4'd3,
        OP_RSHIFT = 4'd4,
        OP_ADD    = 4'd5,
        OP_SUB    = 4'd6,
        OP_MUL    = 4'd7,
        OP_DIV    = 4'd8,
        OP_REM    = 4'd9,
        OP_WRITE  = 4'd10,
        OP_READ   = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CYCLES  = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]        req_type;
        logic [15:0]       word_address;
        logic [WORD_W-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word_result;
        status_t            status;
        logic [COUNT_W-1:0] cycles_used;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic cap_req;
        logic rd_hi;
        logic rd_lo;
        logic exec;
        logic alu;
        logic div_start;
        logic div_take;
        logic wr_hi;
        logic wr_lo;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic write_en;
        logic div_go;
        logic div_done;
    } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/decompressor_vm_word_alu_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decompressor_vm_word_alu_top
// Word alu over the byte memory of a decompressor virtual machine, with a
// cycle budget, a sequencing controller and a datapath with iterative divider.
// ----------------------------------------------------------------------------
//  channel  direction  payload            transfer when
//  req      in         req_t              req_valid & req_ready
//  rsp      out        rsp_t              rsp_valid & rsp_ready
//  cfg      in         32-bit budget      cfg_valid & cfg_ready
//
//  one request at a time through a single-port byte memory: reads, unused
//  codes and failed alu ops skip the byte writes; writes and the other alu
//  ops write both bytes, and div and rem first wait for the 16-step divider.
//  a new request is taken while the previous response still waits in the
//  output register; a stalled response only holds the sequencer in its
//  last step. reset clears the consumed count and the budget; the memory
//  is not cleared. cfg is always ready.
// ----------------------------------------------------------------------------
module decompressor_vm_word_alu_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire dvwa_pkg::req_t               req_data,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output dvwa_pkg::rsp_t                    rsp_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [dvwa_pkg::COUNT_W-1:0] cfg_data
);
    import dvwa_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    dvwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // memory, accounting and alu
    dvwa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_data  (rsp_data)
    );

`ifndef SYNTHESIS
    // one request in flight: no transfer right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while busy");

    // any failure has consumed at least one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.cycles_used != '0))
        else $error("failure with zero consumed cycles");

    // a response is loaded only while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response loaded from idle");
`endif

endmodule

`default_nettype wire

/* rtl/core/dvwa_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvwa_div
// Iterative restoring divider, one quotient bit per cycle, pulses done after
// the last step with quotient and remainder held.
// ----------------------------------------------------------------------------
module dvwa_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dvwa_pkg::WORD_W-1:0] dividend,
    input  wire logic [dvwa_pkg::WORD_W-1:0] divisor,
    output logic                            done,
    output logic [dvwa_pkg::WORD_W-1:0]     quotient,
    output logic [dvwa_pkg::WORD_W-1:0]     remainder
);
    import dvwa_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    dsr_reg, dsr_next;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      trial;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                done_next = 1'b1;
            end
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    // step counter and done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/dvwa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvwa_datapath
// Byte memory, request and word registers, cycle accounting, alu and the
// divider, and the response register, all driven by controller commands.
// ----------------------------------------------------------------------------
module dvwa_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dvwa_pkg::req_t              req_data,
    input  wire logic                        cfg_write,
    input  wire logic [dvwa_pkg::COUNT_W-1:0] cfg_data,
    input  wire dvwa_pkg::dp_cmd_t           cmd,
    output dvwa_pkg::dp_sts_t                sts,
    output dvwa_pkg::rsp_t                   rsp_data
);
    import dvwa_pkg::*;

    logic [7:0]         mem [MEM_BYTES];
    logic [7:0]         rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;

    req_t               req_reg;
    logic [ADDR_W-1:0]  hi_addr_reg, lo_addr_reg;
    logic [ADDR_W-1:0]  hi_addr, lo_addr;
    logic [7:0]         hi_byte_reg;
    logic [WORD_W-1:0]  m_reg;
    logic [WORD_W-1:0]  result_reg, result_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] budget_reg;
    status_t            status_reg, status_next;
    logic               write_en_reg, write_en_next;
    rsp_t               rsp_reg;

    logic [COUNT_W:0]   bumped;
    logic               is_alu;
    logic               is_div;
    logic [WORD_W-1:0]  operand;
    logic [2*WORD_W-1:0] product;
    logic               div_done;
    logic [WORD_W-1:0]  quotient, remainder;

    // address wrap for the word's high and low byte
    assign hi_addr = req_data.word_address[ADDR_W-1:0];
    assign lo_addr = (hi_addr == ADDR_W'(MEM_BYTES - 1)) ? '0 : hi_addr + 1'b1;

    assign operand = req_reg.operand_value;
    assign is_alu  = (req_reg.req_type <= OP_REM);
    assign is_div  = (req_reg.req_type == OP_DIV) || (req_reg.req_type == OP_REM);

    // single port byte memory
    assign mem_we    = cmd.wr_hi | cmd.wr_lo;
    assign mem_re    = cmd.rd_hi | cmd.rd_lo;
    assign mem_addr  = (cmd.rd_lo | cmd.wr_lo) ? lo_addr_reg : hi_addr_reg;
    assign mem_wdata = cmd.wr_lo ? result_reg[7:0] : result_reg[WORD_W-1:8];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // cycle accounting and status decision
    always_comb
    begin
        bumped        = {1'b0, count_reg} + 1'b1;
        count_next    = count_reg;
        status_next   = ST_OK;
        write_en_next = 1'b0;
        if (req_reg.req_type == OP_WRITE)
        begin
            write_en_next = 1'b1;
        end
        else if (is_alu)
        begin
            count_next = bumped[COUNT_W] ? '1 : bumped[COUNT_W-1:0];
            if (bumped > {1'b0, budget_reg})
            begin
                status_next = ST_CYCLES;
            end
            else if (is_div && (operand == '0))
            begin
                status_next = ST_DIVZERO;
            end
            else
            begin
                write_en_next = 1'b1;
            end
        end
    end

    // combinational alu ops, the divider result is loaded later
    assign product = m_reg * operand;

    always_comb
    begin
        result_next = m_reg;
        case (req_reg.req_type)
            OP_AND:    result_next = m_reg & operand;
            OP_OR:     result_next = m_reg | operand;
            OP_NOT:    result_next = ~m_reg;
            OP_LSHIFT: result_next = (operand >= WORD_W'(WORD_W)) ? '0 : m_reg << operand[3:0];
            OP_RSHIFT: result_next = (operand >= WORD_W'(WORD_W)) ? '0 : m_reg >> operand[3:0];
            OP_ADD:    result_next = m_reg + operand;
            OP_SUB:    result_next = m_reg - operand;
            OP_MUL:    result_next = product[WORD_W-1:0];
            OP_WRITE:  result_next = operand;
            default:   result_next = m_reg;
        endcase
    end

    dvwa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (m_reg),
        .divisor   (operand),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // architectural state: consumed count and budget
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            budget_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (cfg_write)
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_reg     <= req_data;
            hi_addr_reg <= hi_addr;
            lo_addr_reg <= lo_addr;
        end
        if (cmd.rd_lo)
        begin
            hi_byte_reg <= rdata_reg;
        end
        if (cmd.exec)
        begin
            m_reg        <= {hi_byte_reg, rdata_reg};
            status_reg   <= status_next;
            write_en_reg <= write_en_next;
        end
        if (cmd.alu)
        begin
            result_reg <= result_next;
        end
        else if (cmd.div_take)
        begin
            result_reg <= (req_reg.req_type == OP_DIV) ? quotient : remainder;
        end
        if (cmd.load_out)
        begin
            rsp_reg.word_result <= write_en_reg ? result_reg : m_reg;
            rsp_reg.status      <= status_reg;
            rsp_reg.cycles_used <= count_reg;
        end
    end

    assign sts.write_en = write_en_reg;
    assign sts.div_go   = write_en_reg & is_div;
    assign sts.div_done = div_done;
    assign rsp_data     = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/dvwa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvwa_ctrl
// Sequencer of one request: read both bytes, account, compute, optionally
// divide, write both bytes if enabled, then load the response register.
// ----------------------------------------------------------------------------
module dvwa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire dvwa_pkg::dp_sts_t sts,
    output dvwa_pkg::dp_cmd_t      cmd
);
    import dvwa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_EXEC,
        S_ALU,
        S_DIV,
        S_WR_HI,
        S_WR_LO,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.cap_req = 1'b1;
                    state_next  = S_RD_HI;
                end
            end
            S_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                cmd.alu = 1'b1;
                if (sts.div_go)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (sts.write_en)
                begin
                    state_next = S_WR_HI;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_WR_HI;
                end
            end
            S_WR_HI:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                cmd.wr_lo  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the decompressor vm word alu against a cycle-free model of its byte
// memory, consumed count and budget. A directed table covers every operation,
// address wrap, large shifts, divide by zero and budget exhaustion. Random
// phases with varied budgets follow, with random idling on both channels and
// one long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module testbench;
    import dvwa_pkg::*;

    // highest code above OP_READ that the block serves as a read
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        req_t               rq;
        logic               typed;
        rsp_t               want;
        logic [COUNT_W-1:0] budget_val;
    } plan_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req_data  = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data  = '0;

    // model state
    logic [7:0]         vm_bytes [0:MEM_BYTES-1];
    logic [COUNT_W-1:0] used_cycles = '0;
    logic [COUNT_W-1:0] vm_budget   = '0;

    rsp_t               owed_results [$];
    logic [15:0]        live_addr [$];
    plan_row_t          stim_plan [$];
    int                 err_count  = 0;
    int                 resp_seen  = 0;

    decompressor_vm_word_alu_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // model of one request: updates memory and count, returns the response
    function automatic rsp_t run_vm_op(input req_t rq);
        logic [15:0] hi_a;
        logic [15:0] lo_a;
        logic [15:0] m;
        logic [15:0] b;
        logic [15:0] r;
        logic [32:0] next;
        rsp_t        res;
        hi_a       = rq.word_address;
        lo_a       = hi_a + 16'd1;
        m          = {vm_bytes[hi_a], vm_bytes[lo_a]};
        b          = rq.operand_value;
        r          = m;
        res.status = ST_OK;
        if (rq.req_type == OP_WRITE)
        begin
            vm_bytes[hi_a] = b[15:8];
            vm_bytes[lo_a] = b[7:0];
        end
        else if (rq.req_type <= OP_REM)
        begin
            // the cycle is consumed before the budget check
            next        = {1'b0, used_cycles} + 33'd1;
            used_cycles = next[32] ? '1 : next[31:0];
            if (next > {1'b0, vm_budget})
                res.status = ST_CYCLES;
            else if ((rq.req_type == OP_DIV || rq.req_type == OP_REM) && b == '0)
                res.status = ST_DIVZERO;
            else
            begin
                case (rq.req_type)
                    OP_AND:    r = m & b;
                    OP_OR:     r = m | b;
                    OP_NOT:    r = ~m;
                    OP_LSHIFT: r = (b >= WORD_W) ? '0 : m << b[3:0];
                    OP_RSHIFT: r = (b >= WORD_W) ? '0 : m >> b[3:0];
                    OP_ADD:    r = m + b;
                    OP_SUB:    r = m - b;
                    OP_MUL:    r = m * b;
                    OP_DIV:    r = m / b;
                    default:   r = m % b;
                endcase
                vm_bytes[hi_a] = r[15:8];
                vm_bytes[lo_a] = r[7:0];
            end
        end
        res.word_result = {vm_bytes[hi_a], vm_bytes[lo_a]};
        res.cycles_used = used_cycles;
        return res;
    endfunction

    function automatic void add_req(input logic [3:0] code, input logic [15:0] addr,
                                    input logic [15:0] operand, input logic typed,
                                    input logic [15:0] word, input status_t st,
                                    input logic [COUNT_W-1:0] cnt);
        plan_row_t row;
        row                    = '0;
        row.kind               = ROW_REQ;
        row.rq.req_type        = code;
        row.rq.word_address    = addr;
        row.rq.operand_value   = operand;
        row.typed              = typed;
        row.want.word_result   = word;
        row.want.status        = st;
        row.want.cycles_used   = cnt;
        stim_plan.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [COUNT_W-1:0] value);
        plan_row_t row;
        row            = '0;
        row.kind       = ROW_CFG;
        row.budget_val = value;
        stim_plan.push_back(row);
    endfunction

    // random request; alu ops and reads only touch words already written
    function automatic req_t make_item();
        req_t rq;
        int   pick;
        int   opick;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            rq.req_type = OP_WRITE;
            if ($urandom_range(0, 1) == 0 || live_addr.size() == 0)
                rq.word_address = 16'($urandom_range(0, MEM_BYTES - 1));
            else
                rq.word_address = live_addr[$urandom_range(0, live_addr.size() - 1)];
            rq.operand_value = 16'($urandom_range(0, 65535));
            return rq;
        end
        if (pick < 23)
            rq.req_type = 4'($urandom_range(OP_READ, OP_SPARE_HI));
        else
            rq.req_type = 4'($urandom_range(OP_AND, OP_REM));
        // chain ops on the newest word half of the time
        if ($urandom_range(0, 1) == 0)
            rq.word_address = live_addr[live_addr.size() - 1];
        else
            rq.word_address = live_addr[$urandom_range(0, live_addr.size() - 1)];
        opick = $urandom_range(0, 99);
        if (rq.req_type == OP_LSHIFT || rq.req_type == OP_RSHIFT)
            rq.operand_value = 16'((opick < 85) ? $urandom_range(0, 20)
                                                : $urandom_range(0, 65535));
        else if (opick < 10)
            rq.operand_value = '0;
        else if (opick < 20)
            rq.operand_value = '1;
        else if (opick < 45)
            rq.operand_value = 16'($urandom_range(1, 16));
        else
            rq.operand_value = 16'($urandom_range(0, 65535));
        return rq;
    endfunction

    // offer one request, hold it until the transfer, then log its response
    task automatic send_req(input req_t rq, input logic typed, input rsp_t typed_rsp);
        rsp_t predicted;
        req_valid <= 1'b1;
        req_data  <= rq;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = run_vm_op(rq);
        owed_results.push_back(typed ? typed_rsp : predicted);
        if (rq.req_type == OP_WRITE)
            live_addr.push_back(rq.word_address);
    endtask

    // sender idle gap, mostly short
    task automatic rest(input logic gaps_on);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 60)
            gap = 0;
        else if (pick < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // budget write once every response is back
    task automatic set_budget(input logic [COUNT_W-1:0] value);
        req_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        vm_budget = value;
    endtask

    // response side ready pattern, with one long hold-off under load
    always @(posedge clk)
    begin
        int stall_left;
        int pick;
        bit pressure_done;
        if (stall_left > 0)
            stall_left--;
        else if (!pressure_done && resp_seen >= 300 && req_valid)
        begin
            pressure_done = 1'b1;
            rsp_ready    <= 1'b0;
            stall_left    = 200;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                rsp_ready  <= 1'b1;
                stall_left  = $urandom_range(0, 7);
            end
            else if (pick < 70)
            begin
                rsp_ready  <= 1'b1;
                stall_left  = $urandom_range(20, 60);
            end
            else if (pick < 95)
            begin
                rsp_ready  <= 1'b0;
                stall_left  = $urandom_range(0, 3);
            end
            else
            begin
                rsp_ready  <= 1'b0;
                stall_left  = $urandom_range(10, 40);
            end
        end
    end

    // compare each response transfer with the oldest owed result
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            resp_seen++;
            if (owed_results.size() == 0)
            begin
                if (err_count < 10)
                    $display("unexpected response: word %h status %0d cycles %0d",
                             rsp_data.word_result, rsp_data.status, rsp_data.cycles_used);
                err_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp_data.word_result !== want.word_result ||
                    rsp_data.status !== want.status ||
                    rsp_data.cycles_used !== want.cycles_used)
                begin
                    if (err_count < 10)
                        $display("mismatch at %0t: word %h/%h status %0d/%0d cycles %0d/%0d",
                                 $realtime, want.word_result, rsp_data.word_result,
                                 want.status, rsp_data.status,
                                 want.cycles_used, rsp_data.cycles_used);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // stimulus
    initial
    begin
        req_t rq;
        logic [COUNT_W-1:0] budget;
        logic gaps_on;

        // budget is zero after reset, so alu ops fail
        add_req(OP_WRITE,  16'h0000, 16'h1234, 1'b1, 16'h1234, ST_OK,      32'd0);
        add_req(OP_READ,   16'h0000, 16'h0000, 1'b1, 16'h1234, ST_OK,      32'd0);
        add_req(OP_ADD,    16'h0000, 16'h0001, 1'b1, 16'h1234, ST_CYCLES,  32'd1);
        add_cfg('1);
        // word at the last byte wraps to address 0
        add_req(OP_WRITE,  16'hFFFF, 16'hABCD, 1'b1, 16'hABCD, ST_OK,      32'd1);
        add_req(OP_READ,   16'h0000, 16'h0000, 1'b1, 16'hCD34, ST_OK,      32'd1);
        add_req(OP_AND,    16'hFFFF, 16'h0F0F, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_OR,     16'h0000, 16'hFFFF, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_NOT,    16'h0000, 16'h5A5A, 1'b0, '0,       ST_OK,      '0);
        // shifts, including amounts of 16 and more
        add_req(OP_WRITE,  16'h0100, 16'h8001, 1'b1, 16'h8001, ST_OK,      32'd4);
        add_req(OP_LSHIFT, 16'h0100, 16'h0010, 1'b1, 16'h0000, ST_OK,      32'd5);
        add_req(OP_WRITE,  16'h0100, 16'h8001, 1'b1, 16'h8001, ST_OK,      32'd5);
        add_req(OP_LSHIFT, 16'h0100, 16'h000F, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_RSHIFT, 16'h0100, 16'hFFFF, 1'b1, 16'h0000, ST_OK,      32'd7);
        // arithmetic wrap and divide by zero
        add_req(OP_WRITE,  16'h0200, 16'hFFFF, 1'b1, 16'hFFFF, ST_OK,      32'd7);
        add_req(OP_ADD,    16'h0200, 16'h0001, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_SUB,    16'h0200, 16'h0001, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_MUL,    16'h0200, 16'hFFFF, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_DIV,    16'h0200, 16'h0000, 1'b1, 16'h0001, ST_DIVZERO, 32'd11);
        add_req(OP_REM,    16'h0200, 16'h0000, 1'b1, 16'h0001, ST_DIVZERO, 32'd12);
        add_req(OP_WRITE,  16'h0202, 16'hFFFF, 1'b1, 16'hFFFF, ST_OK,      32'd12);
        add_req(OP_DIV,    16'h0202, 16'h0007, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_REM,    16'h0202, 16'hFFFF, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_SPARE_HI, 16'h0202, 16'hFFFF, 1'b0, '0,     ST_OK,      '0);
        // budget one above the count: one op passes, then exhaustion wins
        add_cfg(32'd15);
        add_req(OP_ADD,    16'h0200, 16'h0002, 1'b0, '0,       ST_OK,      '0);
        add_req(OP_ADD,    16'h0200, 16'h0002, 1'b1, 16'h0003, ST_CYCLES,  32'd16);
        add_req(OP_DIV,    16'h0200, 16'h0000, 1'b1, 16'h0003, ST_CYCLES,  32'd17);

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (stim_plan[i])
        begin
            if (stim_plan[i].kind == ROW_CFG)
                set_budget(stim_plan[i].budget_val);
            else
            begin
                send_req(stim_plan[i].rq, stim_plan[i].typed, stim_plan[i].want);
                rest(1'b1);
            end
        end

        // random phases under different budgets
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       budget = used_cycles + 32'd60;
                1:       budget = '1;
                2:       budget = '0;
                3:       budget = $urandom;
                4:       budget = used_cycles + $urandom_range(100, 200);
                default: budget = '1;
            endcase
            set_budget(budget);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (112)
            begin
                rq = make_item();
                send_req(rq, 1'b0, '0);
                rest(gaps_on);
            end
        end

        // drain
        req_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (err_count == 0 && owed_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
